// ----- hw/rtl/datetime_difference_us_top_macros.svh -----
// Assertion macros shared by the datetime difference RTL.
`ifndef DATETIME_DIFFERENCE_US_TOP_MACROS_SVH
`define DATETIME_DIFFERENCE_US_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define DTD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("datetime difference assertion failed");
`define DTD_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("datetime difference forbidden condition");
`else
`define DTD_ASSERT(lbl, prop)
`define DTD_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ----- hw/rtl/dtd_pkg.sv -----
`default_nettype none

package dtd_pkg;

  localparam int unsigned YEAR_W = 12;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 12'd4095;

  localparam int unsigned DAYNUM_W = 21;
  localparam int unsigned DAYDIFF_W = 22;
  localparam int unsigned SECDIFF_W = 18;
  localparam int unsigned SUBDIFF_W = 11;
  localparam int unsigned SECTOT_W = 41;
  localparam int unsigned MSTOT_W = 51;
  localparam int unsigned OUT_W = 64;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_YEAR        = 3'd0;
  localparam cfg_idx_t REG_MONTH       = 3'd1;
  localparam cfg_idx_t REG_DAY         = 3'd2;
  localparam cfg_idx_t REG_HOUR        = 3'd3;
  localparam cfg_idx_t REG_MINUTE      = 3'd4;
  localparam cfg_idx_t REG_SECOND      = 3'd5;
  localparam cfg_idx_t REG_MILLISECOND = 3'd6;
  localparam cfg_idx_t REG_MICROSECOND = 3'd7;

  localparam logic [8:0] DAYS_BEFORE_MONTH [16] = '{
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
  };

  typedef struct packed {
    logic signed [DAYDIFF_W-1:0] day_diff;
    logic signed [SECDIFF_W-1:0] sec_diff;
    logic signed [SUBDIFF_W-1:0] ms_diff;
    logic signed [SUBDIFF_W-1:0] us_diff;
  } diff_t;

  // Floor division by 100 for values below 8192 using a reciprocal multiply.
  function automatic logic [6:0] div100(input logic [12:0] x);
    logic [25:0] p;
    p = 26'(x) * 26'd5243;
    return p[25:19];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dtd_daynum.sv -----
`default_nettype none

module dtd_daynum (
  input  wire logic [dtd_pkg::YEAR_W-1:0]   year,
  input  wire logic [3:0]                   month,
  input  wire logic [4:0]                   day,
  output logic      [dtd_pkg::DAYNUM_W-1:0] daynum
);
  import dtd_pkg::*;

  logic [YEAR_W-1:0] y;
  logic [12:0]       y13;
  logic [6:0]        q_y;
  logic              centennial;
  logic              leap;
  logic [12:0]       leaps;
  logic [8:0]        doy;

  always_comb begin
    y = (year > YEAR_MAX) ? YEAR_MAX : year;
    y13 = 13'(y);
    q_y = div100(y13);
    centennial = (y13 == 13'(q_y) * 13'd100);
    leap = (y[1:0] == 2'b00) && (!centennial || (q_y[1:0] == 2'b00));
    leaps = ((y13 + 13'd3) >> 2) - 13'(div100(y13 + 13'd99))
            + 13'(div100(y13 + 13'd399) >> 2);
    doy = DAYS_BEFORE_MONTH[month] + 9'((leap && (month > 4'd2)) ? 1 : 0);
    daynum = DAYNUM_W'(y) * DAYNUM_W'(365) + DAYNUM_W'(leaps)
             + DAYNUM_W'(doy) + DAYNUM_W'(day);
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dtd_scale.sv -----
`default_nettype none

module dtd_scale (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire dtd_pkg::diff_t              in_diff,
  output logic                             out_valid,
  output logic signed [dtd_pkg::OUT_W-1:0] out_value
);
  import dtd_pkg::*;

  localparam logic signed [SECTOT_W-1:0] SEC_PER_DAY = 41'sd86400;
  localparam logic signed [MSTOT_W-1:0]  MS_PER_SEC  = 51'sd1000;
  localparam logic signed [OUT_W-1:0]    US_PER_MS   = 64'sd1000;

  logic                         v_sec_r, v_ms_r, v_out_r;
  logic signed [SECTOT_W-1:0]   sec_tot_r, sec_tot_nxt;
  logic signed [SUBDIFF_W-1:0]  ms_d_r, us_d_r, us_d2_r;
  logic signed [MSTOT_W-1:0]    ms_tot_r, ms_tot_nxt;
  logic signed [OUT_W-1:0]      out_r, out_nxt;

  always_comb begin
    sec_tot_nxt = SECTOT_W'($signed(in_diff.day_diff)) * SEC_PER_DAY
                  + SECTOT_W'($signed(in_diff.sec_diff));
    ms_tot_nxt = MSTOT_W'(sec_tot_r) * MS_PER_SEC + MSTOT_W'(ms_d_r);
    out_nxt = OUT_W'(ms_tot_r) * US_PER_MS + OUT_W'(us_d2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_sec_r <= 1'b0;
      v_ms_r  <= 1'b0;
      v_out_r <= 1'b0;
    end else begin
      v_sec_r <= in_valid;
      v_ms_r  <= v_sec_r;
      v_out_r <= v_ms_r;
    end
    sec_tot_r <= sec_tot_nxt;
    ms_d_r    <= $signed(in_diff.ms_diff);
    us_d_r    <= $signed(in_diff.us_diff);
    ms_tot_r  <= ms_tot_nxt;
    us_d2_r   <= us_d_r;
    out_r     <= out_nxt;
  end

  assign out_valid = v_out_r;
  assign out_value = out_r;

endmodule

`default_nettype wire

// ----- hw/rtl/datetime_difference_us_top.sv -----
// A transaction accepted at a rising edge passes the input register, the difference register
// and the seconds, milliseconds and output registers; out_valid marks it for one cycle.
// Throughput: one transaction per cycle; busy is always low and the pipeline never stalls.
// The slowest stage is the day-number calculation, with its leap-year reciprocal multiplies.
// Reset clears the pipeline valid bits and loads the reference 1970-01-01 00:00:00.000000.
`default_nettype none
`include "datetime_difference_us_top_macros.svh"

module datetime_difference_us_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [11:0]                 in_ts_year,
  input  wire logic [3:0]                  in_ts_month,
  input  wire logic [4:0]                  in_ts_day,
  input  wire logic [4:0]                  in_ts_hour,
  input  wire logic [5:0]                  in_ts_minute,
  input  wire logic [5:0]                  in_ts_second,
  input  wire logic [9:0]                  in_ts_millisecond,
  input  wire logic [9:0]                  in_ts_microsecond,
  output logic                             out_valid,
  output logic signed [dtd_pkg::OUT_W-1:0] out_elapsed_us,
  input  wire logic                        cfg_we,
  input  wire dtd_pkg::cfg_idx_t           cfg_index,
  input  wire logic [11:0]                 cfg_wdata
);
  import dtd_pkg::*;

  logic [11:0] ref_year_r;
  logic [3:0]  ref_month_r;
  logic [4:0]  ref_day_r;
  logic [4:0]  ref_hour_r;
  logic [5:0]  ref_minute_r;
  logic [5:0]  ref_second_r;
  logic [9:0]  ref_ms_r;
  logic [9:0]  ref_us_r;

  logic        v_in_r;
  logic [11:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r;
  logic [5:0]  second_r;
  logic [9:0]  ms_r;
  logic [9:0]  us_r;

  logic [DAYNUM_W-1:0]  ts_daynum, ref_daynum;
  logic [SECDIFF_W-1:0] ts_secs, ref_secs;
  logic                 v_diff_r;
  diff_t                diff_r, diff_nxt;
  logic                 same_ref_date;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_year_r   <= 12'd1970;
      ref_month_r  <= 4'd1;
      ref_day_r    <= 5'd1;
      ref_hour_r   <= 5'd0;
      ref_minute_r <= 6'd0;
      ref_second_r <= 6'd0;
      ref_ms_r     <= 10'd0;
      ref_us_r     <= 10'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_YEAR:        ref_year_r   <= cfg_wdata;
        REG_MONTH:       ref_month_r  <= cfg_wdata[3:0];
        REG_DAY:         ref_day_r    <= cfg_wdata[4:0];
        REG_HOUR:        ref_hour_r   <= cfg_wdata[4:0];
        REG_MINUTE:      ref_minute_r <= cfg_wdata[5:0];
        REG_SECOND:      ref_second_r <= cfg_wdata[5:0];
        REG_MILLISECOND: ref_ms_r     <= cfg_wdata[9:0];
        REG_MICROSECOND: ref_us_r     <= cfg_wdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_in_r <= 1'b0;
    end else begin
      v_in_r <= start && !busy;
    end
    year_r   <= in_ts_year;
    month_r  <= in_ts_month;
    day_r    <= in_ts_day;
    hour_r   <= in_ts_hour;
    minute_r <= in_ts_minute;
    second_r <= in_ts_second;
    ms_r     <= in_ts_millisecond;
    us_r     <= in_ts_microsecond;
  end

  dtd_daynum u_ts_daynum (
    .year   (year_r),
    .month  (month_r),
    .day    (day_r),
    .daynum (ts_daynum)
  );

  dtd_daynum u_ref_daynum (
    .year   (ref_year_r),
    .month  (ref_month_r),
    .day    (ref_day_r),
    .daynum (ref_daynum)
  );

  always_comb begin
    ts_secs = SECDIFF_W'(hour_r) * SECDIFF_W'(3600) + SECDIFF_W'(minute_r) * SECDIFF_W'(60)
              + SECDIFF_W'(second_r);
    ref_secs = SECDIFF_W'(ref_hour_r) * SECDIFF_W'(3600)
               + SECDIFF_W'(ref_minute_r) * SECDIFF_W'(60) + SECDIFF_W'(ref_second_r);
    diff_nxt.day_diff = $signed(DAYDIFF_W'(ts_daynum) - DAYDIFF_W'(ref_daynum));
    diff_nxt.sec_diff = $signed(ts_secs - ref_secs);
    diff_nxt.ms_diff  = $signed(SUBDIFF_W'(ms_r) - SUBDIFF_W'(ref_ms_r));
    diff_nxt.us_diff  = $signed(SUBDIFF_W'(us_r) - SUBDIFF_W'(ref_us_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_diff_r <= 1'b0;
    end else begin
      v_diff_r <= v_in_r;
    end
    diff_r <= diff_nxt;
  end

  dtd_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_diff_r),
    .in_diff   (diff_r),
    .out_valid (out_valid),
    .out_value (out_elapsed_us)
  );

  assign same_ref_date = (year_r == ref_year_r) && (month_r == ref_month_r)
                         && (day_r == ref_day_r);

  `DTD_ASSERT(a_start_gives_result, (start |-> ##5 out_valid))
  `DTD_ASSERT(a_result_has_start, (out_valid |-> $past(start, 5)))
  `DTD_ASSERT(a_same_date_zero_days, ((v_in_r && same_ref_date) |-> (diff_nxt.day_diff == '0)))

endmodule

`default_nettype wire

// ----- test/tb_datetime_difference_us_top.sv -----
`default_nettype none

module tb_datetime_difference_us_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dtd_pkg::*;

  localparam bit [63:0] US_PER_DAY = 64'd86400000000;
  localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
    logic [9:0]  microsecond;
  } stamp_t;

  class elapsed_us_checker;
    stamp_t    ref_stamp;
    bit [63:0] expected_elapsed [$];
    int        mismatches;

    function new();
      ref_stamp = '{year: 12'd1970, month: 4'd1, day: 5'd1, default: '0};
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [11:0] v);
      case (idx)
        REG_YEAR:        ref_stamp.year = v;
        REG_MONTH:       ref_stamp.month = v[3:0];
        REG_DAY:         ref_stamp.day = v[4:0];
        REG_HOUR:        ref_stamp.hour = v[4:0];
        REG_MINUTE:      ref_stamp.minute = v[5:0];
        REG_SECOND:      ref_stamp.second = v[5:0];
        REG_MILLISECOND: ref_stamp.millisecond = v[9:0];
        REG_MICROSECOND: ref_stamp.microsecond = v[9:0];
        default: ;
      endcase
    endfunction

    function bit leap_year(bit [63:0] y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function bit [63:0] days_to_year(bit [63:0] y);
      bit [63:0] leaps;
      leaps = (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
      return 64'd365 * y + leaps;
    endfunction

    function bit [63:0] days_to_month(bit [63:0] y, logic [3:0] m);
      bit [63:0] d;
      d = 64'd0;
      for (int i = 1; i < int'(m) && i <= 12; i++) d += 64'(MONTH_DAYS[i-1]);
      if (leap_year(y) && m > 4'd2) d += 64'd1;
      return d;
    endfunction

    function bit [63:0] clamp_year(logic [11:0] y);
      return (y > YEAR_MAX) ? 64'(YEAR_MAX) : 64'(y);
    endfunction

    function bit [63:0] elapsed_from_ref(stamp_t t);
      bit [63:0] ty, ry, acc;
      stamp_t r;
      r = ref_stamp;
      ty = clamp_year(t.year);
      ry = clamp_year(r.year);
      acc = 64'(t.microsecond) - 64'(r.microsecond);
      acc += 64'd1000 * (64'(t.millisecond) - 64'(r.millisecond));
      acc += 64'd1000000 * (64'(t.second) - 64'(r.second));
      acc += 64'd60000000 * (64'(t.minute) - 64'(r.minute));
      acc += 64'd3600000000 * (64'(t.hour) - 64'(r.hour));
      acc += US_PER_DAY * (64'(t.day) - 64'(r.day));
      acc += US_PER_DAY * (days_to_month(ty, t.month) - days_to_month(ry, r.month));
      acc += US_PER_DAY * (days_to_year(ty) - days_to_year(ry));
      return acc;
    endfunction

    function void note_timestamp(stamp_t t);
      expected_elapsed.push_back(elapsed_from_ref(t));
    endfunction

    function void check_elapsed(logic [63:0] actual);
      bit [63:0] exp_val;
      if (expected_elapsed.size() == 0) begin
        mismatches++;
        $display("%0t: result %0d with no transaction outstanding", $time, $signed(actual));
      end else begin
        exp_val = expected_elapsed.pop_front();
        if (actual !== exp_val) begin
          mismatches++;
          $display("%0t: elapsed_us mismatch, expected %0d, actual %0d",
                   $time, $signed(exp_val), $signed(actual));
        end
      end
    endfunction

    function int pending();
      return expected_elapsed.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  stamp_t      drv;
  logic        out_valid;
  logic signed [OUT_W-1:0] out_elapsed_us;
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  logic [11:0] cfg_wdata;

  elapsed_us_checker sb = new();
  int idle_pct;

  datetime_difference_us_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_ts_year        (drv.year),
    .in_ts_month       (drv.month),
    .in_ts_day         (drv.day),
    .in_ts_hour        (drv.hour),
    .in_ts_minute      (drv.minute),
    .in_ts_second      (drv.second),
    .in_ts_millisecond (drv.millisecond),
    .in_ts_microsecond (drv.microsecond),
    .out_valid         (out_valid),
    .out_elapsed_us    (out_elapsed_us),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_elapsed(out_elapsed_us);
  end

  function automatic stamp_t mk_stamp(int y, int mo, int d, int h, int mi, int s,
                                      int ms, int us);
    stamp_t t;
    t.year = 12'(y);
    t.month = 4'(mo);
    t.day = 5'(d);
    t.hour = 5'(h);
    t.minute = 6'(mi);
    t.second = 6'(s);
    t.millisecond = 10'(ms);
    t.microsecond = 10'(us);
    return t;
  endfunction

  function automatic stamp_t random_stamp();
    stamp_t t;
    int notable_years [10] = '{0, 1, 4, 100, 400, 1600, 1900, 2000, 2100, 4095};
    if ($urandom_range(9) < 3) begin
      t = stamp_t'({$urandom, $urandom});
    end else begin
      t = mk_stamp($urandom_range(4095), $urandom_range(12, 1), $urandom_range(31, 1),
                   $urandom_range(23), $urandom_range(59), $urandom_range(59),
                   $urandom_range(999), $urandom_range(999));
      if ($urandom_range(3) == 0) t.year = 12'(notable_years[$urandom_range(9)]);
    end
    return t;
  endfunction

  task automatic idle_cycle();
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic send_stamp(stamp_t t);
    while ($urandom_range(99) < idle_pct) idle_cycle();
    @(negedge clk);
    start <= 1'b1;
    drv <= t;
    do @(posedge clk); while (busy);
    sb.note_timestamp(t);
  endtask

  task automatic drain();
    idle_cycle();
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [11:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_reference(stamp_t r, logic [11:0] pad);
    write_reg(REG_YEAR, r.year);
    write_reg(REG_MONTH, {pad[11:4], r.month});
    write_reg(REG_DAY, {pad[11:5], r.day});
    write_reg(REG_HOUR, {pad[11:5], r.hour});
    write_reg(REG_MINUTE, {pad[11:6], r.minute});
    write_reg(REG_SECOND, {pad[11:6], r.second});
    write_reg(REG_MILLISECOND, {pad[11:10], r.millisecond});
    write_reg(REG_MICROSECOND, {pad[11:10], r.microsecond});
  endtask

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    stamp_t directed [$];
    stamp_t r;
    logic [11:0] pad;

    rst_n = 1'b0;
    start = 1'b0;
    drv = '0;
    cfg_we = 1'b0;
    cfg_index = REG_YEAR;
    cfg_wdata = '0;
    idle_pct = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed.push_back(mk_stamp(1970, 1, 1, 0, 0, 0, 0, 0));
    directed.push_back(mk_stamp(0, 1, 1, 0, 0, 0, 0, 0));
    directed.push_back(mk_stamp(4095, 12, 31, 23, 59, 59, 999, 999));
    directed.push_back(mk_stamp(2000, 2, 29, 12, 30, 30, 500, 500));
    directed.push_back(mk_stamp(2000, 3, 1, 0, 0, 0, 0, 0));
    directed.push_back(mk_stamp(1900, 3, 1, 0, 0, 0, 0, 0));
    directed.push_back(mk_stamp(2004, 3, 1, 0, 0, 0, 0, 1));
    directed.push_back(mk_stamp(2100, 3, 1, 0, 0, 0, 1, 0));
    directed.push_back(mk_stamp(0, 3, 1, 0, 0, 0, 0, 0));
    directed.push_back(mk_stamp(2024, 0, 1, 0, 0, 0, 0, 0));
    directed.push_back(mk_stamp(2024, 13, 1, 0, 0, 0, 0, 0));
    directed.push_back(mk_stamp(2023, 14, 1, 0, 0, 0, 0, 0));
    directed.push_back(mk_stamp(2000, 15, 15, 6, 7, 8, 9, 10));
    directed.push_back(mk_stamp(1969, 12, 31, 23, 59, 59, 999, 999));
    directed.push_back(mk_stamp(2023, 2, 31, 0, 0, 0, 0, 0));
    directed.push_back(mk_stamp(1970, 1, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_stamp(4095, 15, 31, 31, 63, 63, 1023, 1023));
    directed.push_back(mk_stamp(0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_stamp(1600, 2, 29, 24, 60, 60, 1000, 1000));
    foreach (directed[i]) send_stamp(directed[i]);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          r = '1;
          pad = 12'hFFF;
        end
        1: begin
          r = '0;
          pad = 12'h000;
        end
        2: begin
          r = mk_stamp(4095, 12, 31, 23, 59, 59, 999, 999);
          pad = 12'($urandom);
        end
        default: begin
          r = random_stamp();
          pad = 12'($urandom);
        end
      endcase
      load_reference(r, pad);
      idle_pct = (phase < 2) ? 8 : (phase < 4) ? 85 : 0;
      for (int n = 0; n < 100; n++) begin
        if (n == 50 && phase == 2) drain();
        send_stamp(random_stamp());
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/dtd_pkg.sv
hw/rtl/dtd_daynum.sv
hw/rtl/dtd_scale.sv
hw/rtl/datetime_difference_us_top.sv
test/tb_datetime_difference_us_top.sv
